// ===== hw/rtl/gcdist_pkg.sv =====
// ---------------------------------------------------------------------------
// gcdist_pkg
// Shared constants, types and fixed-point helpers of the great circle
// distance datapath.
// ---------------------------------------------------------------------------
package gcdist_pkg;

   // rotation / vectoring stage count (12 .. 32)
   localparam int unsigned CORDIC_STAGES = 24;

   // angle domain: degrees * 65536
   localparam logic signed [25:0] HALF_TURN    = 26'sd11796480;
   localparam logic signed [25:0] FULL_TURN    = 26'sd23592960;
   localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;

   // degrees-to-radians: PI_Q30 = 45 * RAD_MULT_A + RAD_REM, divisor 45 * 2^19
   localparam logic [26:0] RAD_MULT_A   = 27'd74961320;
   localparam logic [27:0] RAD_REM      = 28'd26;
   localparam logic [27:0] RAD_HALF     = 28'd11796480;
   localparam logic [28:0] DIV45_RECIP  = 29'd381774871;
   localparam int unsigned DIV45_SHIFT  = 34;
   localparam int unsigned RAD_SHIFT    = 19;

   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
   localparam logic [63:0]        ONE_SQ_Q60  = 64'h1000_0000_0000_0000;

   localparam logic [15:0] RADIUS_RESET = 16'd6371;

   typedef struct packed {
      logic signed [31:0] sin_val;
      logic signed [31:0] cos_val;
   } sincos_type;

   // floor(atan(2^-i) * 2^30)
   function automatic logic [31:0] atan_q30(input int unsigned idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd843314856;
         1:  val = 32'd497837829;
         2:  val = 32'd263043836;
         3:  val = 32'd133525158;
         4:  val = 32'd67021686;
         5:  val = 32'd33543515;
         6:  val = 32'd16775850;
         7:  val = 32'd8388437;
         8:  val = 32'd4194282;
         9:  val = 32'd2097149;
         10: val = 32'd1048575;
         11: val = 32'd524287;
         12: val = 32'd262143;
         13: val = 32'd131071;
         14: val = 32'd65535;
         15: val = 32'd32767;
         16: val = 32'd16383;
         17: val = 32'd8191;
         18: val = 32'd4095;
         19: val = 32'd2047;
         20: val = 32'd1023;
         21: val = 32'd511;
         22: val = 32'd255;
         23: val = 32'd127;
         24: val = 32'd63;
         25: val = 32'd31;
         26: val = 32'd15;
         27: val = 32'd7;
         28: val = 32'd3;
         29: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

   // Q1.30 product, rounded half up
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      logic signed [63:0] prod;
      prod = (64'(a) * 64'(b)) + 64'sd536870912;
      return 32'(prod >>> 30);
   endfunction

endpackage

// ===== hw/rtl/great_circle_distance_unit.sv =====
// ---------------------------------------------------------------------------
// great_circle_distance_unit
// Great circle distance by the spherical law of cosines, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one request carries two points (lat/lon, degrees * 65536).
//  - rsp_ channel: one distance per request, in 1/16 of a radius unit,
//    in request order.
//  - csr_ channel: writes the sphere radius; csr_ready is always high.
//    Write it only while no request is in flight.
// Path: input register, three parallel sin/cos CORDICs, two Q1.30
//   multiply stages, the clamp, a 32-step square root, the vectoring
//   CORDIC, the radius multiply, the rounding register and the output
//   register.
// Throughput: one request per cycle while req_ready is high; each stage
//   holds only add/compare logic or multiplies.
// Stall: the whole pipeline advances together. A skid register behind the
//   output register absorbs one result while rsp_ready is low, so req_ready
//   only drops once both are full.
// Reset: synchronous, clears all valid bits and sets the radius to 6371.
// ---------------------------------------------------------------------------
module great_circle_distance_unit import gcdist_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_lat_a,
   input  logic signed [24:0] req_lon_a,
   input  logic signed [23:0] req_lat_b,
   input  logic signed [24:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [21:0]        rsp_distance,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);

   logic en;              // global pipeline advance
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // radius register
   logic [15:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   // input stage: sign extend, longitude difference
   logic signed [25:0] lat_a_ff;
   logic signed [25:0] lat_b_ff;
   logic signed [25:0] dlon_ff;
   logic               in_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lat_a_ff <= 26'(req_lat_a);
         lat_b_ff <= 26'(req_lat_b);
         dlon_ff  <= 26'(req_lon_b) - 26'(req_lon_a);
      end
   end

   // three sin/cos units of equal latency, so one valid suffices
   sincos_type sc_a;
   sincos_type sc_b;
   sincos_type sc_d;
   logic       sc_v;
   logic       sc_v_b;
   logic       sc_v_d;

   gcdist_sincos u_sincos_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .in_angle  (lat_a_ff),
      .out_valid (sc_v),
      .out_data  (sc_a)
   );

   gcdist_sincos u_sincos_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .in_angle  (lat_b_ff),
      .out_valid (sc_v_b),
      .out_data  (sc_b)
   );

   gcdist_sincos u_sincos_d (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_v_ff),
      .in_angle  (dlon_ff),
      .out_valid (sc_v_d),
      .out_data  (sc_d)
   );

   // products: sin*sin and cos*cos, then times cos(dlon)
   logic signed [31:0] pss_ff;
   logic signed [31:0] pcc_ff;
   logic signed [31:0] cd_ff;
   logic               p1_v_ff;
   logic signed [31:0] pss2_ff;
   logic signed [31:0] pccc_ff;
   logic               p2_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pss_ff  <= mul_q30(sc_a.sin_val, sc_b.sin_val);
         pcc_ff  <= mul_q30(sc_a.cos_val, sc_b.cos_val);
         cd_ff   <= sc_d.cos_val;
         pss2_ff <= pss_ff;
         pccc_ff <= mul_q30(pcc_ff, cd_ff);
      end
   end

   // sum and clamp to [-1, 1]
   logic signed [32:0] sum;
   logic signed [31:0] cos_c_in;
   logic signed [31:0] cos_c_ff;
   logic               p3_v_ff;

   always_comb begin
      sum = 33'(pss2_ff) + 33'(pccc_ff);
      if (sum > ONE_Q30) begin
         cos_c_in = 32'(ONE_Q30);
      end else if (sum < -ONE_Q30) begin
         cos_c_in = 32'(-ONE_Q30);
      end else begin
         cos_c_in = 32'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_c_ff <= cos_c_in;
      end
   end

   logic        ac_v;
   logic [31:0] angle;

   gcdist_acos u_acos (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_v_ff),
      .in_cos    (cos_c_ff),
      .out_valid (ac_v),
      .out_angle (angle)
   );

   // radius scaling, rounded to 1/16 unit
   logic [47:0] prod_ff;
   logic        m_v_ff;
   logic [21:0] dist_ff;
   logic        d_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 48'(radius_ff) * 48'(angle);
         dist_ff <= 22'((prod_ff + 48'd33554432) >> 26);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         m_v_ff  <= 1'b0;
         d_v_ff  <= 1'b0;
      end else if (en) begin
         in_v_ff <= req_valid;
         p1_v_ff <= sc_v;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         m_v_ff  <= ac_v;
         d_v_ff  <= m_v_ff;
      end
   end

   // output register plus one skid entry
   logic        out_v_ff;
   logic        out_v_in;
   logic [21:0] out_d_ff;
   logic [21:0] out_d_in;
   logic        skid_v_in;
   logic [21:0] skid_d_ff;
   logic [21:0] skid_d_in;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = d_v_ff;
            out_d_in = dist_ff;
         end
      end else if (d_v_ff && en) begin
         skid_v_in = 1'b1;
         skid_d_in = dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_distance = out_d_ff;

endmodule

// ===== hw/rtl/gcdist_sincos.sv =====
// ---------------------------------------------------------------------------
// gcdist_sincos
// Angle reduction, degree-to-radian scaling and pipelined rotation CORDIC.
// ---------------------------------------------------------------------------
module gcdist_sincos import gcdist_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [25:0] in_angle,
   output logic               out_valid,
   output sincos_type         out_data
);

   // stage R0: wrap and fold
   logic signed [25:0] wrap_val;
   logic signed [25:0] fold_val;
   logic               fold_neg;
   logic signed [23:0] m_ff;
   logic               neg0_ff;
   logic               v0_ff;

   always_comb begin
      wrap_val = in_angle;
      if (in_angle >= HALF_TURN) begin
         wrap_val = in_angle - FULL_TURN;
      end else if (in_angle < -HALF_TURN) begin
         wrap_val = in_angle + FULL_TURN;
      end
      fold_val = wrap_val;
      fold_neg = 1'b0;
      if (wrap_val > QUARTER_TURN) begin
         fold_val = wrap_val - HALF_TURN;
         fold_neg = 1'b1;
      end else if (wrap_val < -QUARTER_TURN) begin
         fold_val = wrap_val + HALF_TURN;
         fold_neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff    <= 24'(fold_val);
         neg0_ff <= fold_neg;
      end
   end

   // stage R1: magnitude products
   logic [22:0] mag;
   logic [27:0] rem_term;
   logic [49:0] prod_a_ff;
   logic [56:0] prod_t_ff;
   logic        sgn1_ff;
   logic        neg1_ff;
   logic        v1_ff;

   assign mag      = 23'(m_ff[23] ? -m_ff : m_ff);
   assign rem_term = 28'(mag) * RAD_REM + RAD_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_a_ff <= 50'(mag) * 50'(RAD_MULT_A);
         prod_t_ff <= 57'(rem_term) * 57'(DIV45_RECIP);
         sgn1_ff   <= m_ff[23];
         neg1_ff   <= neg0_ff;
      end
   end

   // stage R2: radians Q2.29, then angle Q2.30
   logic [22:0]        quot45;
   logic [30:0]        rad29;
   logic signed [33:0] z_mag;

   assign quot45 = 23'(prod_t_ff >> DIV45_SHIFT);
   assign rad29  = 31'((prod_a_ff + 50'(quot45)) >> RAD_SHIFT);
   assign z_mag  = 34'(rad29) <<< 1;

   logic signed [33:0] x_ff [CORDIC_STAGES+1];
   logic signed [33:0] y_ff [CORDIC_STAGES+1];
   logic signed [33:0] z_ff [CORDIC_STAGES+1];
   logic               neg_ff [CORDIC_STAGES+1];
   logic               v_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= sgn1_ff ? -z_mag : z_mag;
         neg_ff[0] <= neg1_ff;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      localparam logic signed [33:0] ATAN = 34'(atan_q30(i));
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            neg_ff[i+1] <= neg_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
   end

   // output stage: undo the half-turn fold
   sincos_type out_ff;
   logic       out_v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.sin_val <= 32'(neg_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES]
                                                      : y_ff[CORDIC_STAGES]);
         out_ff.cos_val <= 32'(neg_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES]
                                                      : x_ff[CORDIC_STAGES]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v_ff[0]  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v0_ff    <= in_valid;
         v1_ff    <= v0_ff;
         v_ff[0]  <= v1_ff;
         out_v_ff <= v_ff[CORDIC_STAGES];
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

// ===== hw/rtl/gcdist_acos.sv =====
// ---------------------------------------------------------------------------
// gcdist_acos
// Arccosine: pipelined integer square root, then vectoring CORDIC.
// ---------------------------------------------------------------------------
module gcdist_acos import gcdist_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] in_cos,
   output logic               out_valid,
   output logic [31:0]        out_angle
);

   localparam int unsigned SQRT_STEPS = 32;

   // stage A0: 1 - S^2 in Q2.60
   logic signed [63:0] sq;
   assign sq = 64'(in_cos) * 64'(in_cos);

   logic [63:0]        v_ff [SQRT_STEPS+1];
   logic [63:0]        r_ff [SQRT_STEPS+1];
   logic signed [31:0] s_ff [SQRT_STEPS+1];
   logic               sv_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0] <= ONE_SQ_Q60 - $unsigned(sq);
         r_ff[0] <= '0;
         s_ff[0] <= in_cos;
      end
   end

   // one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] trial;
      assign trial = r_ff[k] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (v_ff[k] >= trial) begin
               v_ff[k+1] <= v_ff[k] - trial;
               r_ff[k+1] <= (r_ff[k] >> 1) + BIT;
            end else begin
               v_ff[k+1] <= v_ff[k];
               r_ff[k+1] <= r_ff[k] >> 1;
            end
            s_ff[k+1] <= s_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
   end

   // pre-rotation: left half-plane turned by -90 degrees
   logic signed [33:0] root;
   logic signed [33:0] s_ext;
   assign root  = 34'(r_ff[SQRT_STEPS]);
   assign s_ext = 34'(s_ff[SQRT_STEPS]);

   logic signed [33:0] x_ff [CORDIC_STAGES+1];
   logic signed [33:0] y_ff [CORDIC_STAGES+1];
   logic signed [33:0] z_ff [CORDIC_STAGES+1];
   logic               cv_ff [CORDIC_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         if (s_ext < 0) begin
            x_ff[0] <= root;
            y_ff[0] <= -s_ext;
            z_ff[0] <= HALF_PI_Q30;
         end else begin
            x_ff[0] <= s_ext;
            y_ff[0] <= root;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      localparam logic signed [33:0] ATAN = 34'(atan_q30(i));
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end
   end

   // clamp to [0, pi]
   logic [31:0] angle_ff;
   logic        out_v_ff;
   logic signed [33:0] z_last;
   assign z_last = z_ff[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         if (z_last < 0) begin
            angle_ff <= '0;
         end else if (z_last > PI_Q30) begin
            angle_ff <= 32'(PI_Q30);
         end else begin
            angle_ff <= 32'(z_last);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
         cv_ff[0] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= in_valid;
         cv_ff[0] <= sv_ff[SQRT_STEPS];
         out_v_ff <= cv_ff[CORDIC_STAGES];
      end
   end

   assign out_valid = out_v_ff;
   assign out_angle = angle_ff;

endmodule

// ===== hw/rtl/gcdist_checker.sv =====
// ---------------------------------------------------------------------------
// gcdist_checker
// Port-level checks of the great circle distance unit.
// ---------------------------------------------------------------------------
module gcdist_port_checks (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [21:0]        rsp_distance,
   input logic               csr_ready
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("response changed while stalled");

   // backpressure only with a result waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with empty output");

   // distance never exceeds pi * max radius
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distance <= 22'd3294149)
      else $error("distance out of range");

   // nothing leaves the pipeline right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // radius port never pushes back
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("radius port not ready");

endmodule

bind great_circle_distance_unit gcdist_port_checks u_gcdist_port_checks (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance),
   .csr_ready    (csr_ready)
);
